// ===== src/isr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_pkg
// shared types and constants of the integer square root core
// ----------------------------------------------------------------------------
package isr_pkg;

  localparam int unsigned ROOT_W = 32;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

endpackage

// ===== src/isr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_datapath
// digit-by-digit root: two radicand bits in, one root bit out per step
// ----------------------------------------------------------------------------
module isr_datapath
  import isr_pkg::*;
#(
  parameter int unsigned INPUT_BITS = 63
) (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [INPUT_BITS-1:0] radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int unsigned ROOT_BITS = (INPUT_BITS + 1) / 2;
  localparam int unsigned PAD_BITS  = 2 * ROOT_BITS;
  localparam int unsigned REM_W     = ROOT_BITS + 2;

  logic [PAD_BITS-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [REM_W-1:0]     rem_cat;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  always_comb begin
    rem_cat  = {rem_r[REM_W-3:0], rad_r[PAD_BITS-1 -: 2]};
    trial    = {root_r, 2'b01};
    fits     = rem_cat >= trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (cmd.load) begin
      rad_nxt  = PAD_BITS'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cmd.step) begin
      rad_nxt = rad_r << 2;
      if (fits) begin
        rem_nxt  = rem_cat - trial;
        root_nxt = ROOT_BITS'({root_r, 1'b1});
      end else begin
        rem_nxt  = rem_cat;
        root_nxt = ROOT_BITS'({root_r, 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = ROOT_W'(root_r);

endmodule

// ===== src/isr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_ctrl
// sequencer: loads an item, runs one step per root bit, strobes the result
// ----------------------------------------------------------------------------
module isr_ctrl
  import isr_pkg::*;
#(
  parameter int unsigned ROOT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output cmd_t cmd
);

  localparam int unsigned CNT_W = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_BITS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign busy      = state_r == S_RUN;
  assign out_valid = state_r == S_DONE;
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.load  = accept;
    cmd.step  = 1'b0;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        if (accept) begin
          state_nxt = S_RUN;
          cnt_nxt   = CNT_LAST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid && cnt_r == CNT_LAST)
    else $error("accepted item did not start a run");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy && cnt_r == '0 |=> out_valid)
    else $error("last step not followed by result strobe");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// ===== src/integer_square_root_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_core
// floor of the square root of an unsigned INPUT_BITS-bit radicand
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The root is settled
// one bit per cycle by a shared compare-and-subtract step, so out_valid pulses
// for one cycle once the last root bit is settled. busy is low again in the
// strobe cycle, so a new item may be taken there. The receiver cannot
// stall: out_root must be taken in the cycle out_valid is high.
// ----------------------------------------------------------------------------
module integer_square_root_core
  import isr_pkg::*;
#(
  parameter int unsigned INPUT_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [INPUT_BITS-1:0] in_radicand,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root
);

  localparam int unsigned ROOT_BITS = (INPUT_BITS + 1) / 2;

  cmd_t cmd;

  isr_ctrl #(
    .ROOT_BITS (ROOT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  isr_datapath #(
    .INPUT_BITS (INPUT_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .radicand (in_radicand),
    .root     (out_root)
  );

endmodule

// ===== dv/integer_square_root_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_core_test
// self-checking bench for the integer square root core
// ----------------------------------------------------------------------------
// Drives 63-bit radicands through the start/busy handshake. Directed corner
// values go first. Random items follow: full-width values, narrow values and
// values on either side of perfect squares. They are sent in bursts with
// random gaps between them. Every accepted item is turned into an expected
// root by a bitwise trial-square search. Each out_valid strobe is checked
// against the oldest expected root.
// ----------------------------------------------------------------------------
module integer_square_root_core_test;
  import isr_pkg::*;

  localparam int unsigned RADICAND_W = 63;
  localparam logic [31:0] ROOT_MAX = 32'd3037000499;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 100;

  typedef logic [RADICAND_W-1:0] radicand_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef struct {
    radicand_t radicand;
    root_t     root;
  } root_expect_t;

  // floor of the square root, one trial bit at a time from the top
  function automatic root_t floor_sqrt(radicand_t value);
    logic [63:0] trial;
    root_t       acc;
    acc = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = 64'(acc | (root_t'(1) << i));
      if (trial * trial <= 64'(value)) begin
        acc = trial[ROOT_W-1:0];
      end
    end
    return acc;
  endfunction

  class root_scoreboard;
    root_expect_t pending[$];
    int unsigned  fail_count;

    function new();
      fail_count = 0;
    endfunction

    function void note_radicand(radicand_t value);
      root_expect_t e;
      e.radicand = value;
      e.root = floor_sqrt(value);
      pending.push_back(e);
    endfunction

    function void check_root(root_t actual);
      root_expect_t e;
      if (pending.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("%0t: unexpected root item, actual %0d", $time, actual);
        end
        fail_count++;
        return;
      end
      e = pending.pop_front();
      if (actual !== e.root) begin
        if (fail_count < MAX_REPORTS) begin
          $display("%0t: root mismatch for radicand %0d, expected %0d, actual %0d",
                   $time, e.radicand, e.root, actual);
        end
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  radicand_t   in_radicand;
  logic        out_valid;
  root_t       out_root;
  int unsigned cycle_count = 0;

  root_scoreboard roots = new();

  integer_square_root_core #(
    .INPUT_BITS(RADICAND_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_radicand(in_radicand),
    .out_valid  (out_valid),
    .out_root   (out_root)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      roots.check_root(out_root);
    end
    if (rst_n && start && !busy) begin
      roots.note_radicand(in_radicand);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_square_root_core_test: errors");
      $finish;
    end
  end

  function automatic radicand_t pick_radicand();
    logic [63:0] wide;
    logic [63:0] sq;
    root_t       r;
    case ($urandom_range(0, 3))
      0: begin
        wide = {$urandom, $urandom};
      end
      1: begin
        wide = {$urandom, $urandom} >> $urandom_range(1, 63);
      end
      default: begin
        r = $urandom_range(0, ROOT_MAX) >> $urandom_range(0, 31);
        sq = 64'(r) * 64'(r);
        case ($urandom_range(0, 3))
          0: wide = sq - 64'd1;
          1: wide = sq;
          2: wide = sq + 64'd1;
          default: wide = sq + 64'(r) + 64'(r);
        endcase
      end
    endcase
    return wide[RADICAND_W-1:0];
  endfunction

  // holds start high until the item is taken
  task automatic send_radicand(input radicand_t value);
    start <= 1'b1;
    in_radicand <= value;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    in_radicand <= pick_radicand();
    repeat (cycles) @(posedge clk);
  endtask

  radicand_t corner_values[] = '{
    63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd8, 63'd15, 63'd16, 63'd24, 63'd25,
    63'd4294836224, 63'd4294836225, 63'd4611686014132420609,
    (63'd1 << 62) - 63'd1, 63'd1 << 62,
    63'd9223372030926249000, 63'd9223372030926249001, 63'd9223372030926249002,
    63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
    63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF
  };

  initial begin
    int unsigned burst_left;
    rst_n = 1'b0;
    start = 1'b0;
    in_radicand = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) begin
      send_radicand(corner_values[i]);
    end
    pause_sender($urandom_range(1, 40));

    burst_left = $urandom_range(1, 12);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      send_radicand(pick_radicand());
      burst_left--;
      if (burst_left == 0) begin
        // long bursts now and then, so some stretches run with no gaps
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        pause_sender($urandom_range(1, 40));
      end
    end

    start <= 1'b0;
    while (roots.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (roots.fail_count == 0 && roots.outstanding() == 0) begin
      $display("integer_square_root_core_test: clean");
    end else begin
      $display("integer_square_root_core_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/isr_pkg.sv
src/isr_datapath.sv
src/isr_ctrl.sv
src/integer_square_root_core.sv
dv/integer_square_root_core_test.sv
